/* design/b64c_pkg.sv */
// Base64 codec package: channel payload types, group transfer type,
// status codes and the alphabet mapping functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package b64c_pkg;

   // Status codes carried on every result
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD_CHAR = 2'd1;
   localparam logic [1:0] STATUS_BAD_LEN  = 2'd2;

   // Direction register values
   localparam logic DIR_ENCODE = 1'b0;
   localparam logic DIR_DECODE = 1'b1;

   localparam logic [7:0] PAD_CHAR = 8'h3D;  // '='

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_out;
      logic [1:0] status;
   } rsp_type;

   // One finished group: up to four results, item 0 goes out first
   typedef struct packed {
      logic [3:0][7:0] items;
      logic [2:0]      count;
      logic            last;
      logic [1:0]      status;
   } group_type;

   // Sextet to alphabet character
   function automatic logic [7:0] enc_char(input logic [5:0] v);
      logic [7:0] w;
      w = {2'b00, v};
      if (v < 6'd26)      enc_char = 8'h41 + w;
      else if (v < 6'd52) enc_char = 8'h61 + (w - 8'd26);
      else if (v < 6'd62) enc_char = 8'h30 + (w - 8'd52);
      else if (v == 6'd62) enc_char = 8'h2B;
      else                 enc_char = 8'h2F;
   endfunction

   // Character to {valid, sextet}; valid low outside the alphabet
   function automatic logic [6:0] dec_char(input logic [7:0] c);
      logic [7:0] d;
      d = 8'h00;
      if (c >= 8'h41 && c <= 8'h5A) begin
         d = c - 8'h41;
         dec_char = {1'b1, d[5:0]};
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         d = c - 8'h61 + 8'd26;
         dec_char = {1'b1, d[5:0]};
      end else if (c >= 8'h30 && c <= 8'h39) begin
         d = c - 8'h30 + 8'd52;
         dec_char = {1'b1, d[5:0]};
      end else if (c == 8'h2B) begin
         dec_char = {1'b1, 6'd62};
      end else if (c == 8'h2F) begin
         dec_char = {1'b1, 6'd63};
      end else begin
         dec_char = {1'b0, d[5:0]};
      end
   endfunction

endpackage

`default_nettype wire

/* design/b64c_group.sv */
// Group collector: direction register, accumulator state and the
// per-group encode/decode logic that builds a group for the emitter.
// Depends on b64c_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64c_group (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               cfg_wr,
   input  wire logic               cfg_dir,
   input  wire logic               in_valid,
   input  wire b64c_pkg::req_type  in_data,
   output logic                    in_ready,
   input  wire logic               emit_free,
   output logic                    grp_valid,
   output b64c_pkg::group_type     grp
);
   import b64c_pkg::*;

   logic        dir_ff, dir_in;
   logic [23:0] acc_ff, acc_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [1:0]  pad_ff, pad_in;
   logic        bad_ff, bad_in;

   logic        accept;
   logic        will_emit;
   logic [7:0]  b;
   logic        eom;
   logic [23:0] enc_acc, dec_acc;
   logic [1:0]  enc_cnt;
   logic [2:0]  enc_n;
   logic [6:0]  dec_lu;
   logic        is_pad;
   logic [5:0]  sext;
   logic        bad_now;
   logic [1:0]  pad_now;
   logic [2:0]  nbytes;

   assign b   = in_data.in_byte;
   assign eom = in_data.end_of_message;

   // An item that finishes a group needs the emitter free
   assign will_emit = eom || (dir_ff == DIR_ENCODE ? cnt_ff == 2'd2 : cnt_ff == 2'd3);
   assign in_ready  = will_emit ? emit_free : 1'b1;
   assign accept    = in_valid && in_ready;

   // Encode path: merge the byte and decide the character count
   always_comb begin
      unique case (cnt_ff)
         2'd0:    enc_acc = acc_ff | {b, 16'h0000};
         2'd1:    enc_acc = acc_ff | {8'h00, b, 8'h00};
         default: enc_acc = acc_ff | {16'h0000, b};
      endcase
      enc_cnt = cnt_ff + 2'd1;
      enc_n   = (enc_cnt == 2'd0) ? 3'd3 : {1'b0, enc_cnt};
   end

   // Decode path: map the character, track pads and invalid characters
   always_comb begin
      dec_lu  = dec_char(b);
      is_pad  = (b == PAD_CHAR);
      sext    = is_pad ? 6'd0 : dec_lu[5:0];
      bad_now = bad_ff | (!is_pad && !dec_lu[6]);
      pad_now = pad_ff | {is_pad && cnt_ff == 2'd2, is_pad && cnt_ff == 2'd3};
      unique case (cnt_ff)
         2'd0:    dec_acc = acc_ff | {sext, 18'h0};
         2'd1:    dec_acc = acc_ff | {6'h0, sext, 12'h0};
         2'd2:    dec_acc = acc_ff | {12'h0, sext, 6'h0};
         default: dec_acc = acc_ff | {18'h0, sext};
      endcase
      nbytes = 3'd3;
      if (eom) nbytes = 3'd3 - {2'b00, pad_now[1]} - {2'b00, pad_now[0]};
   end

   // Next state and group build
   always_comb begin
      dir_in    = dir_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      pad_in    = pad_ff;
      bad_in    = bad_ff;
      grp_valid = 1'b0;
      grp       = '0;
      if (cfg_wr) begin
         dir_in = cfg_dir;
         acc_in = '0;
         cnt_in = '0;
         pad_in = '0;
         bad_in = 1'b0;
      end else if (accept) begin
         if (dir_ff == DIR_ENCODE) begin
            if (will_emit) begin
               grp_valid   = 1'b1;
               grp.items[0] = enc_char(enc_acc[23:18]);
               grp.items[1] = enc_char(enc_acc[17:12]);
               grp.items[2] = (enc_n >= 3'd2) ? enc_char(enc_acc[11:6]) : PAD_CHAR;
               grp.items[3] = (enc_n >= 3'd3) ? enc_char(enc_acc[5:0]) : PAD_CHAR;
               grp.count    = 3'd4;
               grp.last     = eom;
               grp.status   = STATUS_OK;
               acc_in = '0;
               cnt_in = '0;
               pad_in = '0;
               bad_in = 1'b0;
            end else begin
               acc_in = enc_acc;
               cnt_in = enc_cnt;
            end
         end else begin
            if (cnt_ff != 2'd3 && !eom) begin
               acc_in = dec_acc;
               cnt_in = cnt_ff + 2'd1;
               pad_in = pad_now;
               bad_in = bad_now;
            end else begin
               grp_valid = 1'b1;
               grp.last  = eom;
               if (cnt_ff != 2'd3) begin
                  // short final quartet: one length error result
                  grp.count  = 3'd1;
                  grp.status = STATUS_BAD_LEN;
               end else begin
                  grp.items[0] = dec_acc[23:16];
                  grp.items[1] = dec_acc[15:8];
                  grp.items[2] = dec_acc[7:0];
                  grp.count    = nbytes;
                  grp.status   = bad_now ? STATUS_BAD_CHAR : STATUS_OK;
               end
               acc_in = '0;
               cnt_in = '0;
               pad_in = '0;
               bad_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff <= DIR_ENCODE;
         acc_ff <= '0;
         cnt_ff <= '0;
         pad_ff <= '0;
         bad_ff <= 1'b0;
      end else begin
         dir_ff <= dir_in;
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
         pad_ff <= pad_in;
         bad_ff <= bad_in;
      end
   end

endmodule

`default_nettype wire

/* design/b64c_emit.sv */
// Result emitter: holds one finished group and sends its results one
// transfer per cycle on the result channel while rsp_ready is high.
// Depends on b64c_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64c_emit (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 grp_valid,
   input  wire b64c_pkg::group_type  grp,
   output logic                      emit_free,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output b64c_pkg::rsp_type         rsp_data
);
   import b64c_pkg::*;

   group_type  buf_ff, buf_in;
   logic [2:0] left_ff, left_in;
   logic [1:0] idx_ff, idx_in;

   assign rsp_valid = (left_ff != 3'd0);
   assign emit_free = (left_ff == 3'd0) || (left_ff == 3'd1 && rsp_ready);

   // Current result
   always_comb begin
      rsp_data.out_byte = buf_ff.items[idx_ff];
      rsp_data.last_out = buf_ff.last && left_ff == 3'd1;
      rsp_data.status   = buf_ff.status;
   end

   // Load a new group or step to the next result
   always_comb begin
      buf_in  = buf_ff;
      left_in = left_ff;
      idx_in  = idx_ff;
      if (grp_valid) begin
         buf_in  = grp;
         left_in = grp.count;
         idx_in  = 2'd0;
      end else if (rsp_valid && rsp_ready) begin
         left_in = left_ff - 3'd1;
         idx_in  = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         idx_ff  <= '0;
      end else begin
         left_ff <= left_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

endmodule

`default_nettype wire

/* design/base64_codec_core.sv */
// Base64 codec top level: group collector feeding the result emitter.
// Depends on b64c_pkg, b64c_group and b64c_emit.
//
// Usage:
//   csr_*  : one-bit direction register (0 encode, 1 decode); any write
//            also drops a partially collected group. Always ready.
//   req_*  : input items (byte or character plus end-of-message flag).
//   rsp_*  : results (character or byte, last flag, status).
// Latency: a result appears the cycle after the input transfer that
//   completes its group; the emitter then sends one result per cycle
//   while rsp_ready is high. Throughput: in encoding set by the
//   emitter's single output port, in decoding by the input. Items
//   that do not finish a group are taken even while results drain; an
//   item that finishes a group waits until the emitter's last result
//   is transferred (it may be taken in that same cycle).
// Reset: direction returns to encode, group state and emitter clear.
// Stall: when rsp_ready is low the current result holds and input
//   stops at the next group-finishing item.
`timescale 1ns / 1ps
`default_nettype none

module base64_codec_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic               csr_data,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire b64c_pkg::req_type  req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output b64c_pkg::rsp_type       rsp_data
);
   import b64c_pkg::*;

   logic      emit_free;
   logic      grp_valid;
   group_type grp;
   logic      cfg_wr;

   assign csr_ready = 1'b1;
   assign cfg_wr    = csr_valid && csr_ready;

   b64c_group u_group (
      .clock     (clock),
      .reset     (reset),
      .cfg_wr    (cfg_wr),
      .cfg_dir   (csr_data),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .in_ready  (req_ready),
      .emit_free (emit_free),
      .grp_valid (grp_valid),
      .grp       (grp)
   );

   b64c_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .grp_valid (grp_valid),
      .grp       (grp),
      .emit_free (emit_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
